[rtl/tnt_pkg.sv]
// ----------------------------------------------------------------------------
// tnt_pkg
// Types, widths and state codes shared by the triangle normal/tangent unit.
// ----------------------------------------------------------------------------
package tnt_pkg;

   // configuration of the block
   localparam int INDEX_BITS     = 16;
   localparam int UNIT_FRAC_BITS = 14;

   // field widths
   localparam int IDX_IN_W  = 16;
   localparam int IDX_OUT_W = 16;
   localparam int POS_W     = 24;
   localparam int TEX_W     = 20;
   localparam int UNIT_W    = 16;

   // datapath widths
   localparam int EDGE_W   = POS_W + 1;
   localparam int TDIFF_W  = TEX_W + 1;
   localparam int MUL_W    = 32;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int VEC_W    = 2 * EDGE_W + 2;
   localparam int MAG_W    = VEC_W;
   localparam int NORM_TOP = 31;
   localparam int ROOT_W   = 32;
   localparam int NUM_W    = ROOT_W + UNIT_FRAC_BITS;
   localparam int Q_W      = UNIT_FRAC_BITS + 1;
   localparam int DIV_CNT_W = $clog2(Q_W);
   localparam int STEP_W   = 4;

   // last steps of the sequencer phases
   localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(14);
   localparam logic [STEP_W-1:0] SQ_LAST  = STEP_W'(3);

   typedef struct packed {
      logic [IDX_IN_W-1:0]     vertex_index;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [TEX_W-1:0] tex_u;
      logic signed [TEX_W-1:0] tex_v;
   } tnt_req_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0]     corner_vertex;
      logic signed [UNIT_W-1:0] tangent_x;
      logic signed [UNIT_W-1:0] tangent_y;
      logic signed [UNIT_W-1:0] tangent_z;
      logic signed [UNIT_W-1:0] normal_x;
      logic signed [UNIT_W-1:0] normal_y;
      logic signed [UNIT_W-1:0] normal_z;
      logic                     tangent_degenerate;
      logic                     normal_degenerate;
      logic                     last_of_triangle;
   } tnt_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SIGN,
      ST_LOAD,
      ST_NORM,
      ST_SQ,
      ST_SQRT,
      ST_DIV,
      ST_EMIT
   } tnt_state_type;

endpackage

[rtl/tnt_mul.sv]
// ----------------------------------------------------------------------------
// tnt_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tnt_mul import tnt_pkg::*; (
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  mul_a,
   input  logic signed [MUL_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0] mul_p
);

   logic signed [PROD_W-1:0] prod_ff;

   // one product per cycle
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule

[rtl/tnt_isqrt.sv]
// ----------------------------------------------------------------------------
// tnt_isqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module tnt_isqrt import tnt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic [PROD_W-1:0] rem_ff;
   logic [PROD_W-1:0] res_ff;
   logic [PROD_W-1:0] bit_ff;
   logic              active_ff;
   logic              done_ff;
   logic [PROD_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         done_ff <= active_ff && bit_ff[0];
         if (start) begin
            active_ff <= 1'b1;
         end else if (bit_ff[0]) begin
            active_ff <= 1'b0;
         end
      end
   end

   // restoring root step
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= radicand;
         res_ff <= '0;
         bit_ff <= PROD_W'(1) << (PROD_W - 2);
      end else if (active_ff) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

[rtl/tnt_div.sv]
// ----------------------------------------------------------------------------
// tnt_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tnt_div import tnt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [ROOT_W-1:0] den,
   output logic              done,
   output logic [Q_W-1:0]    quo
);

   logic [NUM_W-1:0]     rem_ff;
   logic [NUM_W-1:0]     dsh_ff;
   logic [Q_W-1:0]       quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 active_ff;
   logic                 done_ff;
   logic                 ge;

   assign ge = rem_ff >= dsh_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= active_ff && (cnt_ff == '0);
         if (start) begin
            active_ff <= 1'b1;
            cnt_ff    <= DIV_CNT_W'(Q_W - 1);
         end else if (active_ff) begin
            if (cnt_ff == '0) begin
               active_ff <= 1'b0;
            end
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // compare and subtract
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         dsh_ff <= NUM_W'(den) << UNIT_FRAC_BITS;
         quo_ff <= '0;
      end else if (active_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         dsh_ff <= dsh_ff >> 1;
         quo_ff <= {quo_ff[Q_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

[rtl/triangle_normal_tangent_unit.sv]
// ----------------------------------------------------------------------------
// triangle_normal_tangent_unit
// Face normal and face tangent of a triangle, built around one shared
// multiplier, an iterative square root and an iterative divider.
// ----------------------------------------------------------------------------
// Corners enter on the req_ channel, one item per corner. The first two
// corners of a triangle are stored and give no result.
// The third corner starts the computation; the block drops req_ready until
// it has handed its three results (one per corner, in arrival order) to the
// rsp_ output register. The last of them has last_of_triangle set.
// The third corner runs products and edge setup on the shared multiplier,
// then per vector (normal, then tangent): a load, one normalization shift
// per bit, squaring on the multiplier, the square root and a division per
// component; a zero vector skips its pass, and a zero uv determinant skips
// the tangent pass.
// Synchronous reset clears the sequencer, the corner count and rsp_valid.
// When the receiver stalls, the waiting result holds in the output register;
// the block takes new corners only once a triangle's last result is in it,
// and a new triangle waits at its first result until the register is free.
// ----------------------------------------------------------------------------
module triangle_normal_tangent_unit import tnt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  tnt_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output tnt_rsp_type rsp_data
);

   tnt_state_type state_ff, state_in;

   logic [1:0]        corner_cnt_ff;
   logic [STEP_W-1:0] step_ff;
   logic              pass_ff;
   logic [1:0]        comp_ff;
   logic [1:0]        emit_ff;
   logic              rsp_valid_ff;
   tnt_rsp_type       rsp_ff;

   // held corners and the third corner
   logic [INDEX_BITS-1:0]   h_idx_ff [2];
   logic signed [POS_W-1:0] h_px_ff  [2];
   logic signed [POS_W-1:0] h_py_ff  [2];
   logic signed [POS_W-1:0] h_pz_ff  [2];
   logic signed [TEX_W-1:0] h_u_ff   [2];
   logic signed [TEX_W-1:0] h_v_ff   [2];
   logic [INDEX_BITS-1:0]   c_idx_ff;
   logic signed [POS_W-1:0] c_px_ff, c_py_ff, c_pz_ff;
   logic signed [TEX_W-1:0] c_u_ff, c_v_ff;

   // products and vectors
   logic signed [PROD_W-1:0] acc_ff;
   logic signed [VEC_W-1:0]  nv_ff [3];
   logic signed [VEC_W-1:0]  tv_ff [3];
   logic signed [VEC_W-1:0]  det_ff;
   logic [MAG_W-1:0]         mag_ff [3];
   logic                     neg_ff [3];
   logic [PROD_W-1:0]        sum_ff;
   logic signed [UNIT_W-1:0] un_ff [3];
   logic signed [UNIT_W-1:0] ut_ff [3];
   logic                     ndeg_ff, tdeg_ff;

   // edges and texture deltas
   logic signed [EDGE_W-1:0]  e1x, e1y, e1z, e2x, e2y, e2z;
   logic signed [TDIFF_W-1:0] du1, dv1, du2, dv2;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [PROD_W-1:0] diff;
   logic [STEP_W-1:0]        coll;
   logic signed [VEC_W-1:0]  vsel [3];
   logic                     vec_zero;
   logic                     mag_over, mag_top;
   logic                     det_zero;
   logic                     pass_finish;
   tnt_state_type            after_pass;
   logic                     req_fire, rsp_load;
   logic                     sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]        root;
   logic                     div_start, div_done;
   logic [Q_W-1:0]           quo;
   logic [NUM_W-1:0]         num;
   logic signed [UNIT_W-1:0] qext, qsgn;

   assign e1x = EDGE_W'(h_px_ff[1]) - EDGE_W'(h_px_ff[0]);
   assign e1y = EDGE_W'(h_py_ff[1]) - EDGE_W'(h_py_ff[0]);
   assign e1z = EDGE_W'(h_pz_ff[1]) - EDGE_W'(h_pz_ff[0]);
   assign e2x = EDGE_W'(c_px_ff) - EDGE_W'(h_px_ff[0]);
   assign e2y = EDGE_W'(c_py_ff) - EDGE_W'(h_py_ff[0]);
   assign e2z = EDGE_W'(c_pz_ff) - EDGE_W'(h_pz_ff[0]);
   assign du1 = TDIFF_W'(h_u_ff[1]) - TDIFF_W'(h_u_ff[0]);
   assign dv1 = TDIFF_W'(h_v_ff[1]) - TDIFF_W'(h_v_ff[0]);
   assign du2 = TDIFF_W'(c_u_ff) - TDIFF_W'(h_u_ff[0]);
   assign dv2 = TDIFF_W'(c_v_ff) - TDIFF_W'(h_v_ff[0]);

   // shared units
   tnt_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   tnt_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sum_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   assign num = (NUM_W'(mag_ff[comp_ff][NORM_TOP-1:0]) << UNIT_FRAC_BITS)
              + NUM_W'(root >> 1);

   tnt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (root),
      .done  (div_done),
      .quo   (quo)
   );

   // misc datapath terms
   assign diff     = acc_ff - mul_p;
   assign coll     = step_ff - 1'b1;
   assign det_zero = (det_ff == '0);
   assign qext     = UNIT_W'(quo);
   assign qsgn     = neg_ff[comp_ff] ? -qext : qext;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vsel[i] = pass_ff ? tv_ff[i] : nv_ff[i];
      end
      vec_zero = (vsel[0] == '0) && (vsel[1] == '0) && (vsel[2] == '0);
      mag_over = 1'b0;
      mag_top  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         mag_over = mag_over | (|mag_ff[i][MAG_W-1:NORM_TOP]);
         mag_top  = mag_top | mag_ff[i][NORM_TOP-1];
      end
   end

   assign after_pass = (!pass_ff && !det_zero) ? ST_LOAD : ST_EMIT;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && corner_cnt_ff == 2'd2) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (step_ff == MUL_LAST) state_in = ST_SIGN;
         end
         ST_SIGN: state_in = ST_LOAD;
         ST_LOAD: begin
            state_in = vec_zero ? after_pass : ST_NORM;
         end
         ST_NORM: begin
            if (!mag_over && mag_top) state_in = ST_SQ;
         end
         ST_SQ: begin
            if (step_ff == SQ_LAST) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sqrt_done) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done && comp_ff == 2'd2) state_in = after_pass;
         end
         ST_EMIT: begin
            if (rsp_load && emit_ff == 2'd2) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      sqrt_start  = (state_ff == ST_SQRT) && (step_ff == '0);
      div_start   = (state_ff == ST_DIV) && (step_ff == '0);
      rsp_load    = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
      pass_finish = ((state_ff == ST_LOAD) && vec_zero)
                 || ((state_ff == ST_DIV) && div_done && comp_ff == 2'd2);
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MUL) begin
         case (step_ff)
            4'd0:    begin mul_a = MUL_W'(e1y); mul_b = MUL_W'(e2z); end
            4'd1:    begin mul_a = MUL_W'(e1z); mul_b = MUL_W'(e2y); end
            4'd2:    begin mul_a = MUL_W'(e1z); mul_b = MUL_W'(e2x); end
            4'd3:    begin mul_a = MUL_W'(e1x); mul_b = MUL_W'(e2z); end
            4'd4:    begin mul_a = MUL_W'(e1x); mul_b = MUL_W'(e2y); end
            4'd5:    begin mul_a = MUL_W'(e1y); mul_b = MUL_W'(e2x); end
            4'd6:    begin mul_a = MUL_W'(du1); mul_b = MUL_W'(dv2); end
            4'd7:    begin mul_a = MUL_W'(du2); mul_b = MUL_W'(dv1); end
            4'd8:    begin mul_a = MUL_W'(dv2); mul_b = MUL_W'(e1x); end
            4'd9:    begin mul_a = MUL_W'(dv1); mul_b = MUL_W'(e2x); end
            4'd10:   begin mul_a = MUL_W'(dv2); mul_b = MUL_W'(e1y); end
            4'd11:   begin mul_a = MUL_W'(dv1); mul_b = MUL_W'(e2y); end
            4'd12:   begin mul_a = MUL_W'(dv2); mul_b = MUL_W'(e1z); end
            4'd13:   begin mul_a = MUL_W'(dv1); mul_b = MUL_W'(e2z); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == ST_SQ) begin
         case (step_ff)
            4'd0:    mul_a = MUL_W'({1'b0, mag_ff[0][NORM_TOP-1:0]});
            4'd1:    mul_a = MUL_W'({1'b0, mag_ff[1][NORM_TOP-1:0]});
            4'd2:    mul_a = MUL_W'({1'b0, mag_ff[2][NORM_TOP-1:0]});
            default: mul_a = '0;
         endcase
         mul_b = mul_a;
      end
   end

   assign req_fire = req_valid && req_ready;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         corner_cnt_ff <= '0;
         step_ff       <= '0;
         pass_ff       <= 1'b0;
         comp_ff       <= '0;
         emit_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            corner_cnt_ff <= (corner_cnt_ff == 2'd2) ? 2'd0 : corner_cnt_ff + 1'b1;
            emit_ff       <= '0;
         end
         case (state_ff)
            ST_MUL, ST_SQ: step_ff <= step_ff + 1'b1;
            ST_SQRT:       step_ff <= STEP_W'(1);
            ST_DIV: begin
               if (div_done) begin
                  step_ff <= '0;
                  comp_ff <= comp_ff + 1'b1;
               end else begin
                  step_ff <= STEP_W'(1);
               end
            end
            ST_SIGN: pass_ff <= 1'b0;
            default: step_ff <= step_ff;
         endcase
         if (state_ff == ST_SQRT && sqrt_done) comp_ff <= '0;
         if (pass_finish) pass_ff <= 1'b1;
         if (state_in != state_ff) step_ff <= '0;
         if (rsp_load) begin
            emit_ff      <= emit_ff + 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (corner_cnt_ff == 2'd2) begin
                  c_idx_ff <= req_data.vertex_index[INDEX_BITS-1:0];
                  c_px_ff  <= req_data.pos_x;
                  c_py_ff  <= req_data.pos_y;
                  c_pz_ff  <= req_data.pos_z;
                  c_u_ff   <= req_data.tex_u;
                  c_v_ff   <= req_data.tex_v;
               end else begin
                  h_idx_ff[corner_cnt_ff[0]] <= req_data.vertex_index[INDEX_BITS-1:0];
                  h_px_ff[corner_cnt_ff[0]]  <= req_data.pos_x;
                  h_py_ff[corner_cnt_ff[0]]  <= req_data.pos_y;
                  h_pz_ff[corner_cnt_ff[0]]  <= req_data.pos_z;
                  h_u_ff[corner_cnt_ff[0]]   <= req_data.tex_u;
                  h_v_ff[corner_cnt_ff[0]]   <= req_data.tex_v;
               end
            end
         end
         // products pair up: first loads, second subtracts
         ST_MUL: begin
            if (step_ff != '0) begin
               if (!coll[0]) begin
                  acc_ff <= mul_p;
               end else begin
                  case (coll[STEP_W-1:1])
                     3'd0:    nv_ff[0] <= diff[VEC_W-1:0];
                     3'd1:    nv_ff[1] <= diff[VEC_W-1:0];
                     3'd2:    nv_ff[2] <= diff[VEC_W-1:0];
                     3'd3:    det_ff   <= diff[VEC_W-1:0];
                     3'd4:    tv_ff[0] <= diff[VEC_W-1:0];
                     3'd5:    tv_ff[1] <= diff[VEC_W-1:0];
                     3'd6:    tv_ff[2] <= diff[VEC_W-1:0];
                     default: acc_ff   <= acc_ff;
                  endcase
               end
            end
         end
         // tangent takes the sign of the uv determinant
         ST_SIGN: begin
            if (det_ff < 0) begin
               for (int i = 0; i < 3; i++) tv_ff[i] <= -tv_ff[i];
            end
         end
         ST_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               neg_ff[i] <= vsel[i] < 0;
               mag_ff[i] <= (vsel[i] < 0) ? MAG_W'(-vsel[i]) : MAG_W'(vsel[i]);
            end
            if (vec_zero) begin
               if (pass_ff) begin
                  tdeg_ff <= 1'b1;
                  for (int i = 0; i < 3; i++) ut_ff[i] <= '0;
               end else begin
                  ndeg_ff <= 1'b1;
                  for (int i = 0; i < 3; i++) un_ff[i] <= '0;
               end
            end
         end
         // bring the largest magnitude into [2^30, 2^31)
         ST_NORM: begin
            for (int i = 0; i < 3; i++) begin
               if (mag_over)      mag_ff[i] <= mag_ff[i] >> 1;
               else if (!mag_top) mag_ff[i] <= mag_ff[i] << 1;
            end
         end
         ST_SQ: begin
            if (step_ff != '0) begin
               sum_ff <= ((step_ff == STEP_W'(1)) ? '0 : sum_ff) + $unsigned(mul_p);
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (pass_ff) begin
                  ut_ff[comp_ff] <= qsgn;
                  tdeg_ff        <= 1'b0;
               end else begin
                  un_ff[comp_ff] <= qsgn;
                  ndeg_ff        <= 1'b0;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               case (emit_ff)
                  2'd0:    rsp_ff.corner_vertex <= IDX_OUT_W'(h_idx_ff[0]);
                  2'd1:    rsp_ff.corner_vertex <= IDX_OUT_W'(h_idx_ff[1]);
                  default: rsp_ff.corner_vertex <= IDX_OUT_W'(c_idx_ff);
               endcase
               rsp_ff.tangent_x          <= ut_ff[0];
               rsp_ff.tangent_y          <= ut_ff[1];
               rsp_ff.tangent_z          <= ut_ff[2];
               rsp_ff.normal_x           <= un_ff[0];
               rsp_ff.normal_y           <= un_ff[1];
               rsp_ff.normal_z           <= un_ff[2];
               rsp_ff.tangent_degenerate <= tdeg_ff;
               rsp_ff.normal_degenerate  <= ndeg_ff;
               rsp_ff.last_of_triangle   <= (emit_ff == 2'd2);
            end
         end
         default: acc_ff <= acc_ff;
      endcase
      // normal pass done with a zero determinant: no tangent pass
      if (pass_finish && !pass_ff && det_zero) begin
         tdeg_ff <= 1'b1;
         for (int i = 0; i < 3; i++) ut_ff[i] <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/tnt_checker.sv]
// ----------------------------------------------------------------------------
// tnt_checker
// Port-level checks on the channels of the normal/tangent unit.
// ----------------------------------------------------------------------------
module tnt_checker import tnt_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input tnt_rsp_type rsp_data
);

   // an offered corner stays offered until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("input item withdrawn while waiting");

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // degenerate normal comes out zeroed
   a_ndeg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.normal_degenerate |->
         rsp_data.normal_x == '0 && rsp_data.normal_y == '0 && rsp_data.normal_z == '0)
      else $error("degenerate normal not zero");

   // degenerate tangent comes out zeroed
   a_tdeg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tangent_degenerate |->
         rsp_data.tangent_x == '0 && rsp_data.tangent_y == '0 && rsp_data.tangent_z == '0)
      else $error("degenerate tangent not zero");

endmodule

bind triangle_normal_tangent_unit tnt_checker u_tnt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the triangle normal/tangent unit against a behavioral predictor of
// face normals and face tangents, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import tnt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   tnt_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   tnt_rsp_type rsp_data;

   tnt_rsp_type expected_corners[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          idle_enable = 1'b1;
   bit          hold_off = 1'b0;

   // predictor state
   logic [1:0]          corner_count;
   tnt_req_type         held_corner[2];

   triangle_normal_tangent_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // integer square root of a 64-bit value
   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= root + bitv) begin
            s = s - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // unit vector in Q1.14, returns 1 for a zero vector
   function automatic bit make_unit(input longint v[3], output logic [15:0] u[3]);
      longint unsigned mag[3];
      bit              neg[3];
      longint unsigned mx, sum, root, q;
      int              len;
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? -v[i] : v[i];
         if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) begin
         for (int i = 0; i < 3; i++) u[i] = '0;
         return 1'b1;
      end
      len = 0;
      while (len < 64 && (mx >> len) != 0) len++;
      for (int i = 0; i < 3; i++) begin
         if (len > 31) mag[i] = mag[i] >> (len - 31);
         else mag[i] = mag[i] << (31 - len);
         sum += mag[i] * mag[i];
      end
      root = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << UNIT_FRAC_BITS) + (root >> 1)) / root;
         if (neg[i]) q = -q;
         u[i] = q[15:0];
      end
      return 1'b0;
   endfunction

   // face normal and tangent for an accepted corner
   task automatic predict_face(input tnt_req_type c);
      longint      e1[3], e2[3], nv[3], tv[3];
      longint      du1, dv1, du2, dv2, det;
      logic [15:0] nu[3], tu[3];
      bit          ndeg, tdeg;
      tnt_rsp_type r;
      if (corner_count < 2) begin
         held_corner[corner_count[0]] = c;
         corner_count++;
         return;
      end
      corner_count = 0;
      e1[0] = longint'(held_corner[1].pos_x) - longint'(held_corner[0].pos_x);
      e1[1] = longint'(held_corner[1].pos_y) - longint'(held_corner[0].pos_y);
      e1[2] = longint'(held_corner[1].pos_z) - longint'(held_corner[0].pos_z);
      e2[0] = longint'(c.pos_x) - longint'(held_corner[0].pos_x);
      e2[1] = longint'(c.pos_y) - longint'(held_corner[0].pos_y);
      e2[2] = longint'(c.pos_z) - longint'(held_corner[0].pos_z);
      nv[0] = e1[1] * e2[2] - e1[2] * e2[1];
      nv[1] = e1[2] * e2[0] - e1[0] * e2[2];
      nv[2] = e1[0] * e2[1] - e1[1] * e2[0];
      ndeg = make_unit(nv, nu);
      du1 = longint'(held_corner[1].tex_u) - longint'(held_corner[0].tex_u);
      dv1 = longint'(held_corner[1].tex_v) - longint'(held_corner[0].tex_v);
      du2 = longint'(c.tex_u) - longint'(held_corner[0].tex_u);
      dv2 = longint'(c.tex_v) - longint'(held_corner[0].tex_v);
      det = du1 * dv2 - du2 * dv1;
      for (int i = 0; i < 3; i++) begin
         tv[i] = dv2 * e1[i] - dv1 * e2[i];
         if (det < 0) tv[i] = -tv[i];
      end
      if (det == 0) begin
         tdeg = 1'b1;
         for (int i = 0; i < 3; i++) tu[i] = '0;
      end else begin
         tdeg = make_unit(tv, tu);
      end
      for (int k = 0; k < 3; k++) begin
         r.corner_vertex = (k == 2) ? c.vertex_index : held_corner[k].vertex_index;
         r.tangent_x = tu[0];
         r.tangent_y = tu[1];
         r.tangent_z = tu[2];
         r.normal_x = nu[0];
         r.normal_y = nu[1];
         r.normal_z = nu[2];
         r.tangent_degenerate = tdeg;
         r.normal_degenerate = ndeg;
         r.last_of_triangle = (k == 2);
         expected_corners.insert(expected_corners.size(), r);
      end
   endtask

   // send one item, at times with a random gap in front
   task automatic send_corner(input tnt_req_type c);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_data <= c;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_face(c);
      @(negedge clock);
   endtask

   // receiver: random stalls, or a long hold-off
   initial begin
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (600) @(negedge clock);
            hold_off = 1'b0;
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      tnt_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_corners.size() == 0) begin
            $error("unexpected result, corner_vertex %0d", rsp_data.corner_vertex);
            error_count++;
         end else begin
            e = expected_corners.pop_front();
            if (rsp_data.corner_vertex !== e.corner_vertex) begin
               $error("corner_vertex exp %0d got %0d", e.corner_vertex,
                      rsp_data.corner_vertex); error_count++; end
            if (rsp_data.tangent_x !== e.tangent_x) begin
               $error("tangent_x exp %0d got %0d", e.tangent_x, rsp_data.tangent_x);
               error_count++; end
            if (rsp_data.tangent_y !== e.tangent_y) begin
               $error("tangent_y exp %0d got %0d", e.tangent_y, rsp_data.tangent_y);
               error_count++; end
            if (rsp_data.tangent_z !== e.tangent_z) begin
               $error("tangent_z exp %0d got %0d", e.tangent_z, rsp_data.tangent_z);
               error_count++; end
            if (rsp_data.normal_x !== e.normal_x) begin
               $error("normal_x exp %0d got %0d", e.normal_x, rsp_data.normal_x);
               error_count++; end
            if (rsp_data.normal_y !== e.normal_y) begin
               $error("normal_y exp %0d got %0d", e.normal_y, rsp_data.normal_y);
               error_count++; end
            if (rsp_data.normal_z !== e.normal_z) begin
               $error("normal_z exp %0d got %0d", e.normal_z, rsp_data.normal_z);
               error_count++; end
            if (rsp_data.tangent_degenerate !== e.tangent_degenerate) begin
               $error("tangent_degenerate exp %0d got %0d", e.tangent_degenerate,
                      rsp_data.tangent_degenerate); error_count++; end
            if (rsp_data.normal_degenerate !== e.normal_degenerate) begin
               $error("normal_degenerate exp %0d got %0d", e.normal_degenerate,
                      rsp_data.normal_degenerate); error_count++; end
            if (rsp_data.last_of_triangle !== e.last_of_triangle) begin
               $error("last_of_triangle exp %0d got %0d", e.last_of_triangle,
                      rsp_data.last_of_triangle); error_count++; end
         end
      end
   end

   function automatic tnt_req_type corner_of(int idx, int x, int y, int z, int u, int v);
      tnt_req_type c;
      c.vertex_index = IDX_IN_W'(idx);
      c.pos_x = POS_W'(x); c.pos_y = POS_W'(y); c.pos_z = POS_W'(z);
      c.tex_u = TEX_W'(u); c.tex_v = TEX_W'(v);
      return c;
   endfunction

   function automatic tnt_req_type random_corner();
      tnt_req_type c;
      c.vertex_index = IDX_IN_W'($urandom);
      c.pos_x = POS_W'($urandom);
      c.pos_y = POS_W'($urandom);
      c.pos_z = POS_W'($urandom);
      c.tex_u = TEX_W'($urandom);
      c.tex_v = TEX_W'($urandom);
      // mostly small coordinates, sometimes full range
      if ($urandom_range(0, 2) != 0) begin
         c.pos_x = $signed(c.pos_x) >>> $urandom_range(0, 20);
         c.pos_y = $signed(c.pos_y) >>> $urandom_range(0, 20);
         c.pos_z = $signed(c.pos_z) >>> $urandom_range(0, 20);
         c.tex_u = $signed(c.tex_u) >>> $urandom_range(0, 16);
         c.tex_v = $signed(c.tex_v) >>> $urandom_range(0, 16);
      end
      return c;
   endfunction

   // simple and degenerate triangles, field extremes
   task automatic test_directed();
      // unit right triangle in xy with plain uv
      send_corner(corner_of(0, 0, 0, 0, 0, 0));
      send_corner(corner_of(1, 4096, 0, 0, 65536, 0));
      send_corner(corner_of(2, 0, 4096, 0, 0, 65536));
      // flipped uv, negative det
      send_corner(corner_of(3, 0, 0, 0, 0, 0));
      send_corner(corner_of(4, 4096, 0, 0, 0, 65536));
      send_corner(corner_of(5, 0, 4096, 0, 65536, 0));
      // collinear points and equal uvs: both degenerate
      send_corner(corner_of(6, 0, 0, 0, 100, 100));
      send_corner(corner_of(7, 10, 10, 10, 100, 100));
      send_corner(corner_of(8, 20, 20, 20, 100, 100));
      // position extremes, uv extremes
      send_corner(corner_of(16'hffff, -8388608, 8388607, -8388608, -524288, 524287));
      send_corner(corner_of(16'h8000, 8388607, -8388608, 8388607, 524287, -524288));
      send_corner(corner_of(16'h7fff, 8388607, 8388607, -8388608, -524288, -524288));
      // nonzero det but zero tangent vector: all corners coincide in space
      send_corner(corner_of(9, 5, 5, 5, 0, 0));
      send_corner(corner_of(10, 5, 5, 5, 65536, 0));
      send_corner(corner_of(11, 5, 5, 5, 0, 65536));
      // all-ones and all-zero bit patterns
      send_corner(corner_of(16'hffff, -1, -1, -1, -1, -1));
      send_corner(corner_of(0, 0, 0, 0, 0, 0));
      send_corner(corner_of(16'h5555, 1, -1, 7, 3, -9));
   endtask

   // random triangles with random idling
   task automatic test_random(int count);
      repeat (count) send_corner(random_corner());
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      hold_off = 1'b1;
      repeat (12) send_corner(random_corner());
      req_valid <= 1'b0;
      wait (!hold_off);
   endtask

   task automatic wait_drained();
      while (expected_corners.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      corner_count = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(60);
      idle_enable = 1'b0;
      test_random(24);
      req_valid <= 1'b0;
      wait_drained();
      if (error_count == 0 && expected_corners.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

[triangle_normal_tangent_unit.f]
rtl/tnt_pkg.sv
rtl/tnt_mul.sv
rtl/tnt_isqrt.sv
rtl/tnt_div.sv
rtl/triangle_normal_tangent_unit.sv
rtl/tnt_checker.sv
test/testbench.sv
